[rtl/llrpe_pkg.sv]
// Shared types and constants for the laser line row peak extractor.
package llrpe_pkg;

	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;

	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned SIZE_W  = 13;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned COORD_W = 13;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 13;

	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 72;

	localparam logic [LEVEL_W-1:0] NOISE_LEVEL_RST   = LEVEL_W'(50);
	localparam logic [SIZE_W-1:0]  FRAME_WIDTH_RST   = SIZE_W'(800);
	localparam logic [SIZE_W-1:0]  FRAME_HEIGHT_RST  = SIZE_W'(600);
	localparam logic [POS_W-1:0]   CENTER_COLUMN_RST = POS_W'(440);
	localparam logic [POS_W-1:0]   CENTER_ROW_RST    = POS_W'(300);

	localparam logic [SIZE_W-1:0] WIDTH_MAX_C  = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] HEIGHT_MAX_C = SIZE_W'(MAX_HEIGHT);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_NOISE_LEVEL   = 3'd0,
		REG_FRAME_WIDTH   = 3'd1,
		REG_FRAME_HEIGHT  = 3'd2,
		REG_CENTER_COLUMN = 3'd3,
		REG_CENTER_ROW    = 3'd4
	} llrpe_reg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] noise_level;
		logic [SIZE_W-1:0]  frame_width;
		logic [SIZE_W-1:0]  frame_height;
		logic [POS_W-1:0]   center_column;
		logic [POS_W-1:0]   center_row;
	} llrpe_cfg_t;

	// Packed lowest field last, so the struct maps straight onto tdata.
	typedef struct packed {
		logic [LEVEL_W-1:0]        peak_level;
		logic [POS_W-1:0]          peak_column;
		logic [POS_W-1:0]          peak_row;
		logic signed [COORD_W-1:0] point_z;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_x;
	} llrpe_point_t;

endpackage

[rtl/llrpe_row_tracker.sv]
// Per-row running maximum, column and row counters, and point formation.
module llrpe_row_tracker
	import llrpe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_accept,
	input  logic [LEVEL_W-1:0] red_level,
	input  llrpe_cfg_t         cfg,
	output logic               emit,
	output llrpe_point_t       point
);

	logic [POS_W-1:0]   column_q;
	logic [POS_W-1:0]   row_q;
	logic [LEVEL_W-1:0] best_level_q;
	logic [POS_W-1:0]   best_column_q;

	logic [LEVEL_W-1:0] level;
	logic [LEVEL_W-1:0] best_level_n;
	logic [POS_W-1:0]   best_column_n;
	logic [POS_W-1:0]   last_column;
	logic [SIZE_W-1:0]  height;
	logic [POS_W-1:0]   row_inc;
	logic [POS_W-1:0]   row_n;
	logic               row_end;
	logic [COORD_W-1:0] x_diff;
	logic [COORD_W-1:0] y_diff;

	always_comb begin
		level = (red_level > cfg.noise_level) ? red_level : '0;

		if (column_q == '0 || level > best_level_q) begin
			best_level_n  = level;
			best_column_n = column_q;
		end else begin
			best_level_n  = best_level_q;
			best_column_n = best_column_q;
		end

		// Saturate width to 1..MAX_WIDTH, then take width minus one.
		if (cfg.frame_width == '0) begin
			last_column = '0;
		end else if (cfg.frame_width >= WIDTH_MAX_C) begin
			last_column = POS_W'(WIDTH_MAX_C - SIZE_W'(1));
		end else begin
			last_column = POS_W'(cfg.frame_width - SIZE_W'(1));
		end

		if (cfg.frame_height == '0) begin
			height = SIZE_W'(1);
		end else if (cfg.frame_height > HEIGHT_MAX_C) begin
			height = HEIGHT_MAX_C;
		end else begin
			height = cfg.frame_height;
		end

		row_end = (column_q >= last_column);
		row_inc = row_q + POS_W'(1);
		row_n   = (row_inc == '0 || {1'b0, row_inc} >= height) ? '0 : row_inc;

		x_diff = {1'b0, best_column_n} - {1'b0, cfg.center_column};
		y_diff = {1'b0, row_q} - {1'b0, cfg.center_row};

		emit              = pix_accept && row_end && (best_column_n != '0);
		point.point_x     = signed'(x_diff);
		point.point_y     = signed'(y_diff);
		point.point_z     = signed'(x_diff);
		point.peak_row    = row_q;
		point.peak_column = best_column_n;
		point.peak_level  = best_level_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q      <= '0;
			row_q         <= '0;
			best_level_q  <= '0;
			best_column_q <= '0;
		end else if (pix_accept) begin
			best_level_q  <= best_level_n;
			best_column_q <= best_column_n;
			if (row_end) begin
				column_q <= '0;
				row_q    <= row_n;
			end else begin
				column_q <= column_q + POS_W'(1);
			end
		end
	end

endmodule

[rtl/laser_line_row_peak_extractor.sv]
// Top level of the laser line row peak extractor: config registers and output stage.
//
//  channel   dir  handshake                  content
//  s_axis    in   s_axis_tvalid/tready       one red byte per pixel, raster order
//  m_axis    out  m_axis_tvalid/tready       one point per row with a peak off column 0
//  cfg       in   cfg_wr_en                  register index and write data
//
// One pixel item per cycle while s_axis_tready is high; the row maximum compare and counter
// update are registered in the tracker, and the point lands in one output register.
// Reset loads the register defaults and clears counters and the running maximum.
// Input is taken whenever the output register is empty or is being drained, so a
// stall on m_axis holds s_axis_tready low only while a point waits.
module laser_line_row_peak_extractor
	import llrpe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] red_level
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [12:0] point_x, [25:13] point_y, [38:26] point_z, [50:39] peak_row,
	// [62:51] peak_column, [70:63] peak_level, [71] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	llrpe_cfg_t   cfg_q;
	llrpe_point_t point;
	llrpe_point_t point_q;
	logic         emit;
	logic         out_valid_q;
	logic         in_accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_level   <= NOISE_LEVEL_RST;
			cfg_q.frame_width   <= FRAME_WIDTH_RST;
			cfg_q.frame_height  <= FRAME_HEIGHT_RST;
			cfg_q.center_column <= CENTER_COLUMN_RST;
			cfg_q.center_row    <= CENTER_ROW_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_NOISE_LEVEL:   cfg_q.noise_level   <= cfg_data[LEVEL_W-1:0];
				REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data[SIZE_W-1:0];
				REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_data[SIZE_W-1:0];
				REG_CENTER_COLUMN: cfg_q.center_column <= cfg_data[POS_W-1:0];
				REG_CENTER_ROW:    cfg_q.center_row    <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	llrpe_row_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_accept (in_accept),
		.red_level  (s_axis_tdata[LEVEL_W-1:0]),
		.cfg        (cfg_q),
		.emit       (emit),
		.point      (point)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the payload unless a new point is loaded.
	always_ff @(posedge clk) begin
		if (emit) begin
			point_q <= point;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, point_q};

endmodule
